@@ rtl/sven_pkg.sv @@
// ----------------------------------------------------------------------------
// sven_pkg: shared types and constants of the smooth vertex normal engine
// Item structs, op codes, register indexes and widths of the shared units.
// ----------------------------------------------------------------------------
package sven_pkg;

  // Widths fixed by the item fields
  localparam int COORD_BITS = 16;
  localparam int IDX_BITS   = 10;
  localparam int VCNT_BITS  = 11;
  localparam int LEN_BITS   = 32;
  localparam int NORM_BITS  = 16;

  // Defaults for the top level parameters
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int SUM_BITS_DEF     = 48;

  // Edge and face normal widths
  localparam int EDGE_BITS = COORD_BITS + 1;
  localparam int FACE_BITS = 2 * COORD_BITS + 3;

  // Shared multiplier
  localparam int MUL_BITS  = 33;
  localparam int PROD_BITS = 2 * MUL_BITS;

  // Shared root / divide unit
  localparam int RD_BITS          = 52;
  localparam int RD_CNT_BITS      = 5;
  localparam int ROOT_STEPS       = 26;
  localparam int DIV_STEPS        = 15;
  localparam int ROOT_START_SHIFT = RD_BITS - 2;
  localparam int DIV_SHIFT        = 14;
  localparam int ROOT_BITS        = 26;

  // Op codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TRI   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Register indexes
  localparam logic CFG_VCOUNT = 1'b0;
  localparam logic CFG_MINLEN = 1'b1;

  localparam logic [LEN_BITS-1:0]         MINLEN_RESET = 32'd429497;
  localparam logic signed [NORM_BITS-1:0] UNIT_ONE     = 16'sd16384;

  typedef struct packed {
    logic [1:0]                   op;
    logic [IDX_BITS-1:0]          vertex_index;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic [IDX_BITS-1:0]          corner_a;
    logic [IDX_BITS-1:0]          corner_b;
    logic [IDX_BITS-1:0]          corner_c;
  } in_item_t;

  typedef struct packed {
    logic                        status;
    logic signed [NORM_BITS-1:0] normal_x;
    logic signed [NORM_BITS-1:0] normal_y;
    logic signed [NORM_BITS-1:0] normal_z;
    logic                        used_default;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } rd_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rd_stat_t;

endpackage

@@ rtl/sven_mul.sv @@
// ----------------------------------------------------------------------------
// sven_mul: shared signed multiplier
// One registered signed product per cycle while en_i is high, for cross products and squares.
// ----------------------------------------------------------------------------
module sven_mul (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [sven_pkg::MUL_BITS-1:0]  a_i,
  input  logic signed [sven_pkg::MUL_BITS-1:0]  b_i,
  output logic signed [sven_pkg::PROD_BITS-1:0] prod_o
);

  logic signed [sven_pkg::PROD_BITS-1:0] prod_q;

  // Register the product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/sven_store.sv @@
// ----------------------------------------------------------------------------
// sven_store: vertex and accumulator memories
// One write and one registered read port on each memory.
// ----------------------------------------------------------------------------
module sven_store #(
  parameter int MAX_VERTICES = sven_pkg::MAX_VERTICES_DEF,
  parameter int SUM_BITS     = sven_pkg::SUM_BITS_DEF,
  localparam int AW          = $clog2(MAX_VERTICES),
  localparam int VW          = 3 * sven_pkg::COORD_BITS,
  localparam int SW          = 3 * SUM_BITS
) (
  input  logic          clk_i,
  input  logic [AW-1:0] addr_i,
  input  logic          vtx_we_i,
  input  logic [VW-1:0] vtx_wdata_i,
  input  logic          vtx_re_i,
  output logic [VW-1:0] vtx_rdata_o,
  input  logic          sum_we_i,
  input  logic [SW-1:0] sum_wdata_i,
  input  logic          sum_re_i,
  output logic [SW-1:0] sum_rdata_o
);

  logic [VW-1:0] vtx_mem [MAX_VERTICES];
  logic [SW-1:0] sum_mem [MAX_VERTICES];
  logic [VW-1:0] vtx_rdata_q;
  logic [SW-1:0] sum_rdata_q;

  // Vertex memory
  always_ff @(posedge clk_i) begin
    if (vtx_we_i) begin
      vtx_mem[addr_i] <= vtx_wdata_i;
    end
    if (vtx_re_i) begin
      vtx_rdata_q <= vtx_mem[addr_i];
    end
  end

  // Accumulator memory
  always_ff @(posedge clk_i) begin
    if (sum_we_i) begin
      sum_mem[addr_i] <= sum_wdata_i;
    end
    if (sum_re_i) begin
      sum_rdata_q <= sum_mem[addr_i];
    end
  end

  assign vtx_rdata_o = vtx_rdata_q;
  assign sum_rdata_o = sum_rdata_q;

endmodule

@@ rtl/sven_rootdiv.sv @@
// ----------------------------------------------------------------------------
// sven_rootdiv: iterative square root and divide unit
// One compare and subtract per cycle: one result bit of root per step or
// one quotient bit per step.
// ----------------------------------------------------------------------------
module sven_rootdiv (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sven_pkg::rd_ctrl_t               ctrl_i,
  input  logic [sven_pkg::RD_BITS-1:0]     oper_i,
  input  logic [sven_pkg::RD_BITS-1:0]     divisor_i,
  output sven_pkg::rd_stat_t               stat_o,
  output logic [sven_pkg::RD_BITS-1:0]     result_o
);

  localparam int RW = sven_pkg::RD_BITS;

  logic [RW-1:0]                    acc_q, res_q, bit_q;
  logic [sven_pkg::RD_CNT_BITS-1:0] cnt_q;
  logic                             sqrt_q, busy_q, done_q;
  logic [RW-1:0]                    trial, diff;
  logic                             ge;

  // Trial value and shared compare / subtract
  always_comb begin
    trial = sqrt_q ? (res_q + bit_q) : bit_q;
    ge    = (acc_q >= trial);
    diff  = acc_q - trial;
  end

  // Step the iteration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      res_q  <= '0;
      bit_q  <= '0;
      cnt_q  <= '0;
      sqrt_q <= 1'b0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        acc_q  <= oper_i;
        res_q  <= '0;
        sqrt_q <= ctrl_i.sqrt_mode;
        bit_q  <= ctrl_i.sqrt_mode ? (RW'(1) << sven_pkg::ROOT_START_SHIFT)
                                   : (divisor_i << sven_pkg::DIV_SHIFT);
        cnt_q  <= ctrl_i.sqrt_mode ? sven_pkg::RD_CNT_BITS'(sven_pkg::ROOT_STEPS)
                                   : sven_pkg::RD_CNT_BITS'(sven_pkg::DIV_STEPS);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (ge) begin
          acc_q <= diff;
        end
        if (sqrt_q) begin
          res_q <= (res_q >> 1) + (ge ? bit_q : '0);
          bit_q <= bit_q >> 2;
        end else begin
          res_q <= {res_q[RW-2:0], ge};
          bit_q <= bit_q >> 1;
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == sven_pkg::RD_CNT_BITS'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign result_o    = res_q;

endmodule

@@ rtl/smooth_vertex_normal_engine.sv @@
// ----------------------------------------------------------------------------
// smooth_vertex_normal_engine: area-weighted smooth vertex normals
// Stores vertices, accumulates face normals per vertex and returns unit
// normals in Q1.14 on query.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on in_valid_i / in_data_i and are taken when in_stall_o
//   is low; the block takes one item at a time. Every item gives exactly one
//   result item on out_valid_o / out_data_o, held until out_stall_i is low.
//   Registers are to be written through cfg_we_i / cfg_idx_i / cfg_data_i
//   only while idle; the block itself does not enforce this.
// Steps per item: a load writes the vertex; a rejected item goes straight to
//   its result; a triangle takes three vertex reads, six products on the
//   shared multiplier and three accumulator read-modify-writes; a query
//   gives the up normal for an all-zero sum or a squared length not above
//   min_length_sq; other queries make n one-bit normalizing shifts (at most
//   24 for 48-bit sums), then the 26-step root and three 15-step divides on
//   the shared root / divide unit.
// The next item is taken as soon as a result moves to the output register,
// so a stalled receiver blocks input only once a second result is ready.
// Reset clears the registers (vertex count 0, min_length_sq 429497) and the
// output register; the memories hold whatever they held and need loading.
// ----------------------------------------------------------------------------
module smooth_vertex_normal_engine #(
  parameter int MAX_VERTICES = sven_pkg::MAX_VERTICES_DEF,
  parameter int SUM_BITS     = sven_pkg::SUM_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sven_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sven_pkg::out_item_t   out_data_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [31:0]           cfg_data_i
);

  localparam int C   = sven_pkg::COORD_BITS;
  localparam int S   = SUM_BITS;
  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int IW  = (AW > sven_pkg::IDX_BITS) ? AW : sven_pkg::IDX_BITS;
  localparam int EW  = sven_pkg::EDGE_BITS;
  localparam int FW  = sven_pkg::FACE_BITS;
  localparam int MW  = sven_pkg::MUL_BITS;
  localparam int PW  = sven_pkg::PROD_BITS;
  localparam int RW  = sven_pkg::RD_BITS;
  localparam int NW  = sven_pkg::NORM_BITS;
  localparam int QW  = sven_pkg::ROOT_BITS;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_LOAD   = 15'b000000000000010,
    S_VRD    = 15'b000000000000100,
    S_MUL    = 15'b000000000001000,
    S_ACC_RD = 15'b000000000010000,
    S_ACC_WR = 15'b000000000100000,
    S_Q_RD   = 15'b000000001000000,
    S_Q_MAG  = 15'b000000010000000,
    S_Q_CHK  = 15'b000000100000000,
    S_Q_SQ   = 15'b000001000000000,
    S_Q_NORM = 15'b000010000000000,
    S_Q_SQ2  = 15'b000100000000000,
    S_Q_ROOT = 15'b001000000000000,
    S_Q_DIV  = 15'b010000000000000,
    S_DONE   = 15'b100000000000000
  } state_e;

  state_e                        state_q;
  sven_pkg::in_item_t            item_q;
  logic [sven_pkg::VCNT_BITS-1:0] vcount_q;
  logic [sven_pkg::LEN_BITS-1:0] minlen_q;
  logic [2:0]                    cnt_q;
  logic signed [C-1:0]           vx_q [3];
  logic signed [C-1:0]           vy_q [3];
  logic signed [C-1:0]           vz_q [3];
  logic signed [FW-1:0]          f_q [3];
  logic [S-1:0]                  m_q [3];
  logic                          neg_q [3];
  logic [PW-1:0]                 len_q;
  logic [QW-1:0]                 root_q;
  logic signed [NW-1:0]          res_q [3];
  logic                          status_q, default_q, launched_q;
  sven_pkg::out_item_t           out_q;
  logic                          out_valid_q;

  // Range checks on the incoming item
  function automatic logic in_max(input logic [sven_pkg::IDX_BITS-1:0] idx);
    return 32'(idx) < 32'(MAX_VERTICES);
  endfunction

  logic in_cnt_a, in_cnt_b, in_cnt_c, in_cnt_v;
  always_comb begin
    in_cnt_a = in_max(in_data_i.corner_a) &&
               (sven_pkg::VCNT_BITS'(in_data_i.corner_a) < vcount_q);
    in_cnt_b = in_max(in_data_i.corner_b) &&
               (sven_pkg::VCNT_BITS'(in_data_i.corner_b) < vcount_q);
    in_cnt_c = in_max(in_data_i.corner_c) &&
               (sven_pkg::VCNT_BITS'(in_data_i.corner_c) < vcount_q);
    in_cnt_v = in_max(in_data_i.vertex_index) &&
               (sven_pkg::VCNT_BITS'(in_data_i.vertex_index) < vcount_q);
  end

  // Decode the incoming item: where it goes and whether it is in range
  state_e in_next;
  logic   in_ok;
  always_comb begin
    case (in_data_i.op)
      sven_pkg::OP_LOAD: begin
        in_ok   = in_max(in_data_i.vertex_index);
        in_next = S_LOAD;
      end
      sven_pkg::OP_TRI: begin
        in_ok   = in_cnt_a && in_cnt_b && in_cnt_c;
        in_next = S_VRD;
      end
      sven_pkg::OP_QUERY: begin
        in_ok   = in_cnt_v;
        in_next = S_Q_RD;
      end
      default: begin
        in_ok   = 1'b0;
        in_next = S_DONE;
      end
    endcase
  end

  // Select the memory address
  logic [sven_pkg::IDX_BITS-1:0] corner_sel, idx_sel;
  logic [IW-1:0]                 idx_ext;
  logic [AW-1:0]                 addr;
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    corner_sel = item_q.corner_a;
      2'd1:    corner_sel = item_q.corner_b;
      default: corner_sel = item_q.corner_c;
    endcase
    idx_sel = (state_q == S_VRD || state_q == S_ACC_RD || state_q == S_ACC_WR) ?
              corner_sel : item_q.vertex_index;
    idx_ext = IW'(idx_sel);
    addr    = idx_ext[AW-1:0];
  end

  // Memories
  logic [3*C-1:0] vtx_rdata;
  logic [3*S-1:0] sum_rdata, sum_wdata;
  logic           vtx_re, sum_re, sum_we;

  assign vtx_re = (state_q == S_VRD) && (cnt_q != 3'd3);
  assign sum_re = (state_q == S_ACC_RD) || (state_q == S_Q_RD);
  assign sum_we = (state_q == S_ACC_WR) || (state_q == S_LOAD);

  sven_store #(
    .MAX_VERTICES (MAX_VERTICES),
    .SUM_BITS     (SUM_BITS)
  ) u_store (
    .clk_i       (clk_i),
    .addr_i      (addr),
    .vtx_we_i    (state_q == S_LOAD),
    .vtx_wdata_i ({item_q.coord_z, item_q.coord_y, item_q.coord_x}),
    .vtx_re_i    (vtx_re),
    .vtx_rdata_o (vtx_rdata),
    .sum_we_i    (sum_we),
    .sum_wdata_i (sum_wdata),
    .sum_re_i    (sum_re),
    .sum_rdata_o (sum_rdata)
  );

  // Edges of the triangle
  logic signed [EW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  assign e1x = EW'(vx_q[1]) - EW'(vx_q[0]);
  assign e1y = EW'(vy_q[1]) - EW'(vy_q[0]);
  assign e1z = EW'(vz_q[1]) - EW'(vz_q[0]);
  assign e2x = EW'(vx_q[2]) - EW'(vx_q[0]);
  assign e2y = EW'(vy_q[2]) - EW'(vy_q[0]);
  assign e2z = EW'(vz_q[2]) - EW'(vz_q[0]);

  // Multiplier operands
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic [1:0]           sq_idx;
  logic                 mul_en;
  always_comb begin
    sq_idx = (cnt_q[1:0] == 2'd3) ? 2'd0 : cnt_q[1:0];
    mul_a  = '0;
    mul_b  = '0;
    if (state_q == S_MUL) begin
      case (cnt_q)
        3'd0:    begin mul_a = MW'(e1y); mul_b = MW'(e2z); end
        3'd1:    begin mul_a = MW'(e1z); mul_b = MW'(e2y); end
        3'd2:    begin mul_a = MW'(e1z); mul_b = MW'(e2x); end
        3'd3:    begin mul_a = MW'(e1x); mul_b = MW'(e2z); end
        3'd4:    begin mul_a = MW'(e1x); mul_b = MW'(e2y); end
        3'd5:    begin mul_a = MW'(e1y); mul_b = MW'(e2x); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else begin
      mul_a = $signed({1'b0, m_q[sq_idx][31:0]});
      mul_b = $signed({1'b0, m_q[sq_idx][31:0]});
    end
  end
  assign mul_en = (state_q == S_MUL) || (state_q == S_Q_SQ) || (state_q == S_Q_SQ2);

  sven_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Face normal term from the product
  logic [1:0]           f_idx;
  logic [2:0]           cnt_m1;
  logic signed [FW-1:0] prod_f;
  logic [PW-1:0]        len_next;
  assign cnt_m1   = cnt_q - 3'd1;
  assign f_idx    = cnt_m1[2:1];
  assign prod_f   = FW'(prod);
  assign len_next = len_q + $unsigned(prod);

  // Saturating accumulate
  logic signed [S-1:0] s_old [3];
  logic signed [S:0]   s_wide [3];
  logic signed [S-1:0] s_new [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s_old[k]  = $signed(sum_rdata[k*S +: S]);
      s_wide[k] = (S+1)'(s_old[k]) + (S+1)'(f_q[k]);
      if (s_wide[k][S] != s_wide[k][S-1]) begin
        s_new[k] = s_wide[k][S] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
      end else begin
        s_new[k] = s_wide[k][S-1:0];
      end
    end
    sum_wdata = (state_q == S_LOAD) ? '0 : {s_new[2], s_new[1], s_new[0]};
  end

  // Largest magnitude
  logic [S-1:0] top;
  always_comb begin
    top = m_q[0];
    if (m_q[1] > top) top = m_q[1];
    if (m_q[2] > top) top = m_q[2];
  end

  // Root / divide unit
  sven_pkg::rd_ctrl_t rd_ctrl;
  sven_pkg::rd_stat_t rd_stat;
  logic [RW-1:0]      rd_oper, rd_div, rd_result;
  always_comb begin
    rd_ctrl.start     = (state_q == S_Q_ROOT || state_q == S_Q_DIV) && !launched_q;
    rd_ctrl.sqrt_mode = (state_q == S_Q_ROOT);
    rd_div            = RW'(root_q);
    if (state_q == S_Q_ROOT) begin
      rd_oper = len_q[RW-1:0];
    end else begin
      rd_oper = (RW'(m_q[sq_idx][23:0]) << sven_pkg::DIV_SHIFT) + RW'(root_q >> 1);
    end
  end

  sven_rootdiv u_rootdiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (rd_ctrl),
    .oper_i    (rd_oper),
    .divisor_i (rd_div),
    .stat_o    (rd_stat),
    .result_o  (rd_result)
  );

  logic [NW-1:0] quot;
  logic          out_free;
  assign quot     = rd_result[NW-1:0];
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      vcount_q    <= '0;
      minlen_q    <= sven_pkg::MINLEN_RESET;
      cnt_q       <= '0;
      len_q       <= '0;
      root_q      <= '0;
      status_q    <= 1'b0;
      default_q   <= 1'b0;
      launched_q  <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        vx_q[k]  <= '0;
        vy_q[k]  <= '0;
        vz_q[k]  <= '0;
        f_q[k]   <= '0;
        m_q[k]   <= '0;
        neg_q[k] <= 1'b0;
        res_q[k] <= '0;
      end
    end else begin
      // Take register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sven_pkg::CFG_VCOUNT: vcount_q <= cfg_data_i[sven_pkg::VCNT_BITS-1:0];
          sven_pkg::CFG_MINLEN: minlen_q <= cfg_data_i;
          default: ;
        endcase
      end

      // Drop the result once taken, unless a new one replaces it
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q    <= in_data_i;
            status_q  <= !in_ok;
            default_q <= 1'b0;
            cnt_q     <= '0;
            for (int k = 0; k < 3; k++) res_q[k] <= '0;
            if (in_ok) state_q <= in_next;
            else state_q <= S_DONE;
          end
        end

        S_LOAD: state_q <= S_DONE;

        // Read the three corners
        S_VRD: begin
          if (cnt_q != 3'd0) begin
            vx_q[cnt_m1[1:0]] <= vtx_rdata[C-1:0];
            vy_q[cnt_m1[1:0]] <= vtx_rdata[2*C-1:C];
            vz_q[cnt_m1[1:0]] <= vtx_rdata[3*C-1:2*C];
          end
          if (cnt_q == 3'd3) begin
            cnt_q   <= '0;
            state_q <= S_MUL;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end

        // Cross product, one product a cycle
        S_MUL: begin
          if (cnt_q != 3'd0) begin
            f_q[f_idx] <= cnt_m1[0] ? (f_q[f_idx] - prod_f) : prod_f;
          end
          if (cnt_q == 3'd6) begin
            cnt_q   <= '0;
            state_q <= S_ACC_RD;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end

        S_ACC_RD: state_q <= S_ACC_WR;

        S_ACC_WR: begin
          if (cnt_q == 3'd2) begin
            state_q <= S_DONE;
          end else begin
            cnt_q   <= cnt_q + 3'd1;
            state_q <= S_ACC_RD;
          end
        end

        S_Q_RD: state_q <= S_Q_MAG;

        // Split the sums into sign and magnitude
        S_Q_MAG: begin
          for (int k = 0; k < 3; k++) begin
            neg_q[k] <= s_old[k][S-1];
            m_q[k]   <= s_old[k][S-1] ? (S'(0) - s_old[k]) : s_old[k];
          end
          state_q <= S_Q_CHK;
        end

        S_Q_CHK: begin
          len_q <= '0;
          cnt_q <= '0;
          if (top == '0) begin
            res_q[1]  <= sven_pkg::UNIT_ONE;
            default_q <= 1'b1;
            state_q   <= S_DONE;
          end else if (|m_q[0][S-1:32] || |m_q[1][S-1:32] || |m_q[2][S-1:32]) begin
            state_q <= S_Q_NORM;
          end else begin
            state_q <= S_Q_SQ;
          end
        end

        // Squared length against the threshold
        S_Q_SQ: begin
          if (cnt_q != 3'd0) len_q <= len_next;
          if (cnt_q == 3'd3) begin
            if (len_next > PW'(minlen_q)) begin
              state_q <= S_Q_NORM;
            end else begin
              res_q[1]  <= sven_pkg::UNIT_ONE;
              default_q <= 1'b1;
              state_q   <= S_DONE;
            end
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end

        // Bring the largest magnitude into [2^23, 2^24)
        S_Q_NORM: begin
          len_q <= '0;
          cnt_q <= '0;
          if (|top[S-1:24]) begin
            for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 1;
          end else if (!top[23]) begin
            for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] << 1;
          end else begin
            state_q <= S_Q_SQ2;
          end
        end

        S_Q_SQ2: begin
          if (cnt_q != 3'd0) len_q <= len_next;
          if (cnt_q == 3'd3) begin
            state_q <= S_Q_ROOT;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end

        S_Q_ROOT: begin
          if (!launched_q) launched_q <= 1'b1;
          if (rd_stat.done) begin
            root_q     <= rd_result[QW-1:0];
            launched_q <= 1'b0;
            cnt_q      <= '0;
            state_q    <= S_Q_DIV;
          end
        end

        // Divide each magnitude by the root
        S_Q_DIV: begin
          if (!launched_q) launched_q <= 1'b1;
          if (rd_stat.done) begin
            res_q[sq_idx] <= neg_q[sq_idx] ? -$signed(quot) : $signed(quot);
            launched_q    <= 1'b0;
            if (cnt_q == 3'd2) state_q <= S_DONE;
            else cnt_q <= cnt_q + 3'd1;
          end
        end

        // Hand the result to the output register
        S_DONE: begin
          if (out_free) begin
            out_q.status       <= status_q;
            out_q.normal_x     <= res_q[0];
            out_q.normal_y     <= res_q[1];
            out_q.normal_z     <= res_q[2];
            out_q.used_default <= default_q;
            out_valid_q        <= 1'b1;
            state_q            <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Ignored items carry no normal
  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status) |->
      (out_data_o.normal_x == '0 && out_data_o.normal_y == '0 &&
       out_data_o.normal_z == '0 && !out_data_o.used_default))
    else $error("ignored item carries a normal");

  // Default normal is the up vector
  a_default_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.used_default) |->
      (out_data_o.normal_x == '0 && out_data_o.normal_z == '0 &&
       out_data_o.normal_y == sven_pkg::UNIT_ONE))
    else $error("default normal is not the up vector");

  // Root / divide unit never restarted while busy
  a_rd_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_ctrl.start |-> !rd_stat.busy)
    else $error("root/divide unit started while busy");

  // A finished item with a free slot shows up next cycle
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not handed to output register");

endmodule
